>>> rtl/smmd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smmd_pkg
// Shared constants and types for the segment min/max decimator.
// ----------------------------------------------------------------------------
package smmd_pkg;

    localparam int SAMPLE_WIDTH_DEF = 24;
    localparam int SEG_SIZE_W       = 17;
    localparam int BYTE_W           = 8;

    localparam logic [SEG_SIZE_W-1:0] SEG_SIZE_RESET = SEG_SIZE_W'(256);
    localparam logic [SEG_SIZE_W-1:0] SEG_SIZE_MIN   = SEG_SIZE_W'(1);

    // Offset of +1.0 in the 16-bit fraction format.
    localparam int FRAC_ONE = 65536;
    // Right shift that divides by 2.0 in the same format.
    localparam int PROJ_SHIFT = 17;

    typedef struct packed {
        logic emit;
        logic done;
    } smmd_ctl_t;

endpackage

>>> rtl/segment_min_max_decimator_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// segment_min_max_decimator_unit
// Min/max envelope decimation of one channel into byte-projected segments.
//
// Channel   Direction  Handshake             Payload
// input     in         in_valid / in_stall   sample, end_of_channel
// output    out        out_valid / out_stall min_byte, max_byte, channel_done,
//                                            channel_min, channel_max
// config    in         cfg_wr_en             cfg_wr_data (segment_size)
//
// One sample is taken every cycle while in_stall is low.
// A result passes the s1 sample register, then the output register.
// Reset clears the segment count and channel state; segment_size resets to 256.
// A stalled output holds only samples that would produce a further result;
// samples that close no segment keep flowing.
// ----------------------------------------------------------------------------
module segment_min_max_decimator_unit
    import smmd_pkg::*;
#(
    parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_wr_en,
    input  logic        [SEG_SIZE_W-1:0]   cfg_wr_data,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic signed [SAMPLE_WIDTH-1:0] sample,
    input  logic                           end_of_channel,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic        [BYTE_W-1:0]       min_byte,
    output logic        [BYTE_W-1:0]       max_byte,
    output logic                           channel_done,
    output logic signed [SAMPLE_WIDTH-1:0] channel_min,
    output logic signed [SAMPLE_WIDTH-1:0] channel_max
);

    logic        [SEG_SIZE_W-1:0]   seg_size_reg;
    logic                           s1_valid_reg, s1_valid_next;
    logic signed [SAMPLE_WIDTH-1:0] s1_sample_reg;
    logic                           s1_eoc_reg;
    logic                           out_valid_reg, out_valid_next;
    logic        [BYTE_W-1:0]       min_byte_reg, max_byte_reg;
    logic                           done_reg;
    logic signed [SAMPLE_WIDTH-1:0] chan_min_reg, chan_max_reg;

    smmd_ctl_t                      ctl;
    logic                           advance;
    logic        [BYTE_W-1:0]       core_min_byte, core_max_byte;
    logic signed [SAMPLE_WIDTH-1:0] core_chan_min, core_chan_max;

    assign advance  = s1_valid_reg && (!ctl.emit || !out_valid_reg || !out_stall);
    assign in_stall = s1_valid_reg && !advance;

    always_comb
    begin
        s1_valid_next  = in_stall ? s1_valid_reg : in_valid;
        out_valid_next = (advance && ctl.emit) || (out_valid_reg && out_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seg_size_reg  <= SEG_SIZE_RESET;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                seg_size_reg <= cfg_wr_data;
            end
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            s1_sample_reg <= sample;
            s1_eoc_reg    <= end_of_channel;
        end
        if (advance && ctl.emit)
        begin
            min_byte_reg <= core_min_byte;
            max_byte_reg <= core_max_byte;
            done_reg     <= ctl.done;
            chan_min_reg <= core_chan_min;
            chan_max_reg <= core_chan_max;
        end
    end

    smmd_core #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_core (
        .clk            (clk),
        .rst_n          (rst_n),
        .advance        (advance),
        .sample         (s1_sample_reg),
        .end_of_channel (s1_eoc_reg),
        .seg_size       (seg_size_reg),
        .ctl            (ctl),
        .min_byte       (core_min_byte),
        .max_byte       (core_max_byte),
        .chan_min       (core_chan_min),
        .chan_max       (core_chan_max)
    );

    assign out_valid    = out_valid_reg;
    assign min_byte     = min_byte_reg;
    assign max_byte     = max_byte_reg;
    assign channel_done = done_reg;
    assign channel_min  = chan_min_reg;
    assign channel_max  = chan_max_reg;

    a_stall_only_when_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (s1_valid_reg && ctl.emit && out_valid_reg && out_stall))
        else $error("input stalled without a pending result");

    a_result_has_source: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !$past(out_valid_reg)) |-> $past(advance && ctl.emit))
        else $error("result appeared without a processed sample");

    a_min_not_above_max: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (min_byte_reg <= max_byte_reg))
        else $error("segment min byte above max byte");

    a_chan_zero_midway: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !done_reg) |-> (chan_min_reg == '0 && chan_max_reg == '0))
        else $error("channel extremes nonzero before channel end");

    a_chan_order: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && done_reg) |-> (chan_min_reg <= chan_max_reg))
        else $error("channel minimum above channel maximum");

endmodule

>>> rtl/smmd_proj.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smmd_proj
// Projects a signed 16-fraction-bit sample onto a byte, clamped to 0..255.
// ----------------------------------------------------------------------------
module smmd_proj
    import smmd_pkg::*;
#(
    parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
)
(
    input  logic signed [SAMPLE_WIDTH-1:0] sample,
    output logic        [BYTE_W-1:0]       byte_val
);

    logic signed [SAMPLE_WIDTH:0]   shifted;
    logic        [SAMPLE_WIDTH+8:0] scaled;
    logic        [SAMPLE_WIDTH-9:0] quot;

    assign shifted = (SAMPLE_WIDTH+1)'(sample) + (SAMPLE_WIDTH+1)'(FRAC_ONE);
    assign scaled  = {shifted, 8'd0} - {{8{shifted[SAMPLE_WIDTH]}}, shifted};
    assign quot    = scaled[SAMPLE_WIDTH+8:PROJ_SHIFT];

    always_comb
    begin
        if (shifted[SAMPLE_WIDTH] || (shifted == '0))
        begin
            byte_val = '0;
        end
        else if (|quot[SAMPLE_WIDTH-9:BYTE_W])
        begin
            byte_val = '1;
        end
        else
        begin
            byte_val = quot[BYTE_W-1:0];
        end
    end

endmodule

>>> rtl/smmd_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smmd_core
// Segment and channel extreme tracking, segment fill count and result values.
// ----------------------------------------------------------------------------
module smmd_core
    import smmd_pkg::*;
#(
    parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           advance,
    input  logic signed [SAMPLE_WIDTH-1:0] sample,
    input  logic                           end_of_channel,
    input  logic        [SEG_SIZE_W-1:0]   seg_size,
    output smmd_ctl_t                      ctl,
    output logic        [BYTE_W-1:0]       min_byte,
    output logic        [BYTE_W-1:0]       max_byte,
    output logic signed [SAMPLE_WIDTH-1:0] chan_min,
    output logic signed [SAMPLE_WIDTH-1:0] chan_max
);

    logic signed [SAMPLE_WIDTH-1:0] seg_low_reg,  seg_low_next;
    logic signed [SAMPLE_WIDTH-1:0] seg_high_reg, seg_high_next;
    logic signed [SAMPLE_WIDTH-1:0] chan_low_reg, chan_low_next;
    logic signed [SAMPLE_WIDTH-1:0] chan_high_reg, chan_high_next;
    logic        [SEG_SIZE_W-1:0]   fill_reg, fill_next;
    logic                           started_reg, started_next;
    logic        [SEG_SIZE_W-1:0]   fill_inc;
    logic        [SEG_SIZE_W-1:0]   size_eff;

    always_comb
    begin
        seg_low_next   = (fill_reg == '0 || sample < seg_low_reg) ? sample : seg_low_reg;
        seg_high_next  = (fill_reg == '0 || sample > seg_high_reg) ? sample : seg_high_reg;
        chan_low_next  = (!started_reg || sample < chan_low_reg) ? sample : chan_low_reg;
        chan_high_next = (!started_reg || sample > chan_high_reg) ? sample : chan_high_reg;
        fill_inc       = fill_reg + SEG_SIZE_W'(1);
        size_eff       = (seg_size == '0) ? SEG_SIZE_MIN : seg_size;
        ctl.done       = end_of_channel;
        ctl.emit       = (fill_inc >= size_eff) || (fill_inc == '0) || end_of_channel;
        fill_next      = ctl.emit ? '0 : fill_inc;
        started_next   = !end_of_channel;
        chan_min       = end_of_channel ? chan_low_next : '0;
        chan_max       = end_of_channel ? chan_high_next : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seg_low_reg   <= '0;
            seg_high_reg  <= '0;
            chan_low_reg  <= '0;
            chan_high_reg <= '0;
            fill_reg      <= '0;
            started_reg   <= 1'b0;
        end
        else if (advance)
        begin
            seg_low_reg   <= seg_low_next;
            seg_high_reg  <= seg_high_next;
            chan_low_reg  <= chan_low_next;
            chan_high_reg <= chan_high_next;
            fill_reg      <= fill_next;
            started_reg   <= started_next;
        end
    end

    smmd_proj #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_proj_min (
        .sample   (seg_low_next),
        .byte_val (min_byte)
    );

    smmd_proj #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_proj_max (
        .sample   (seg_high_next),
        .byte_val (max_byte)
    );

endmodule

>>> sim/segment_min_max_decimator_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// segment_min_max_decimator_unit_test
// Self-checking bench for the segment min/max decimator. A queue-fed driver
// sends samples in bursts, with random gaps in most phases. A monitor checks every output
// transfer against a cycle-free model of the segment and channel extremes.
// Segment sizes change between phases, including mid-segment and mid-channel.
// ----------------------------------------------------------------------------
module segment_min_max_decimator_unit_test;
    import smmd_pkg::*;

    localparam int SW = SAMPLE_WIDTH_DEF;

    typedef struct packed {
        logic signed [SW-1:0] value;
        logic                 last;
    } sample_item_t;

    typedef struct packed {
        logic [BYTE_W-1:0]    lo_byte;
        logic [BYTE_W-1:0]    hi_byte;
        logic                 done;
        logic signed [SW-1:0] lo_raw;
        logic signed [SW-1:0] hi_raw;
    } envelope_t;

    typedef enum int {STALL_NONE, STALL_RANDOM, STALL_RUNS} stall_mode_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cfg_wr_en = 1'b0;
    logic [SEG_SIZE_W-1:0]  cfg_wr_data = '0;
    logic                   in_valid = 1'b0;
    logic                   in_stall;
    logic signed [SW-1:0]   sample = '0;
    logic                   end_of_channel = 1'b0;
    logic                   out_valid;
    logic                   out_stall = 1'b0;
    logic [BYTE_W-1:0]      min_byte;
    logic [BYTE_W-1:0]      max_byte;
    logic                   channel_done;
    logic signed [SW-1:0]   channel_min;
    logic signed [SW-1:0]   channel_max;

    // Model state of the decimator.
    logic signed [SW-1:0]   seg_lo = '0;
    logic signed [SW-1:0]   seg_hi = '0;
    logic signed [SW-1:0]   chan_lo = '0;
    logic signed [SW-1:0]   chan_hi = '0;
    logic [SEG_SIZE_W-1:0]  seg_count = '0;
    logic [SEG_SIZE_W-1:0]  seg_size = SEG_SIZE_RESET;
    logic                   chan_open = 1'b0;

    sample_item_t           sample_feed[$];
    envelope_t              pending_envelopes[$];

    bit                     gaps_on = 1'b0;
    stall_mode_t            stall_mode = STALL_NONE;
    int                     burst_left = 0;
    int                     gap_left = 0;
    int                     stall_run = 0;

    int                     mismatches = 0;
    int                     samples_sent = 0;
    int                     segments_seen = 0;
    int                     channels_seen = 0;
    int                     size_writes = 0;

    segment_min_max_decimator_unit u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .sample         (sample),
        .end_of_channel (end_of_channel),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .min_byte       (min_byte),
        .max_byte       (max_byte),
        .channel_done   (channel_done),
        .channel_min    (channel_min),
        .channel_max    (channel_max)
    );

    always #2 clk = ~clk;

    function automatic logic [BYTE_W-1:0] project_byte(input logic signed [SW-1:0] s);
        longint t;
        longint p;
        t = longint'(s) + FRAC_ONE;
        if (t <= 0)
            return '0;
        p = (t * 255) >>> PROJ_SHIFT;
        if (p > 255)
            return 8'd255;
        return p[BYTE_W-1:0];
    endfunction

    function automatic bit fold_sample(input sample_item_t smp, output envelope_t env);
        logic signed [SW-1:0]  s;
        logic [SEG_SIZE_W-1:0] limit;
        s = smp.value;
        limit = (seg_size == '0) ? SEG_SIZE_MIN : seg_size;
        env = '0;
        if (seg_count == '0)
        begin
            seg_lo = s;
            seg_hi = s;
        end
        else
        begin
            if (s < seg_lo)
                seg_lo = s;
            if (s > seg_hi)
                seg_hi = s;
        end
        if (!chan_open)
        begin
            chan_lo = s;
            chan_hi = s;
            chan_open = 1'b1;
        end
        else
        begin
            if (s < chan_lo)
                chan_lo = s;
            if (s > chan_hi)
                chan_hi = s;
        end
        seg_count = seg_count + 1'b1;
        if (seg_count >= limit || seg_count == '0 || smp.last)
        begin
            env.lo_byte = project_byte(seg_lo);
            env.hi_byte = project_byte(seg_hi);
            env.done = smp.last;
            env.lo_raw = smp.last ? chan_lo : '0;
            env.hi_raw = smp.last ? chan_hi : '0;
            seg_count = '0;
            if (smp.last)
            begin
                chan_open = 1'b0;
                chan_lo = '0;
                chan_hi = '0;
            end
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic void note_mismatch(input string msg);
        mismatches++;
        if (mismatches <= 10)
            $display("%0t ns mismatch: %s", $time, msg);
    endfunction

    function automatic logic signed [SW-1:0] random_sample();
        logic [31:0] r;
        int near;
        r = $urandom;
        near = 0;
        case ($urandom_range(0, 5))
            0, 1: return r[SW-1:0];
            2: return r[0] ? {1'b1, {(SW-1){1'b0}}} : {1'b0, {(SW-1){1'b1}}};
            3, 4: near = int'($urandom_range(0, 2 * FRAC_ONE + 8)) - FRAC_ONE - 4;
            default: near = int'($urandom_range(0, 4 * FRAC_ONE)) - 2 * FRAC_ONE;
        endcase
        return near[SW-1:0];
    endfunction

    task automatic push_sample(input logic signed [SW-1:0] v, input logic last);
        sample_item_t smp;
        smp.value = v;
        smp.last = last;
        sample_feed.insert(sample_feed.size(), smp);
    endtask

    task automatic drain();
        while (sample_feed.size() > 0 || pending_envelopes.size() > 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_segment_size(input logic [SEG_SIZE_W-1:0] v);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        seg_size = v;
        size_writes++;
    endtask

    task automatic queue_channels(input int count, input int max_len);
        int len;
        int k;
        while (count > 0)
        begin
            len = $urandom_range(1, max_len);
            if (len >= count)
            begin
                len = count;
                for (k = 0; k < len; k++)
                    push_sample(random_sample(), (k == len - 1) && ($urandom_range(0, 2) != 0));
            end
            else
            begin
                for (k = 0; k < len; k++)
                    push_sample(random_sample(), k == len - 1);
            end
            count -= len;
        end
    endtask

    // Sender: holds a stalled transfer, otherwise presents the next sample in bursts.
    always @(posedge clk)
    begin
        envelope_t env;
        logic next_valid;
        next_valid = in_valid;
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                samples_sent++;
                if (fold_sample(sample_feed[0], env))
                    pending_envelopes.insert(pending_envelopes.size(), env);
                void'(sample_feed.pop_front());
                next_valid = 1'b0;
            end
            if (!next_valid)
            begin
                if (gap_left > 0)
                    gap_left--;
                else if (sample_feed.size() > 0)
                begin
                    sample <= sample_feed[0].value;
                    end_of_channel <= sample_feed[0].last;
                    next_valid = 1'b1;
                    if (burst_left > 0)
                        burst_left--;
                    else
                    begin
                        burst_left = $urandom_range(1, 12);
                        gap_left = gaps_on ? $urandom_range(1, 6) : 0;
                    end
                end
            end
        end
        in_valid <= next_valid;
    end

    // Receiver stall pattern.
    always @(posedge clk)
    begin
        logic next_stall;
        case (stall_mode)
            STALL_NONE:
                next_stall = 1'b0;
            STALL_RANDOM:
                next_stall = ($urandom_range(0, 99) < 35);
            default:
            begin
                if (stall_run > 0)
                begin
                    stall_run--;
                    next_stall = out_stall;
                end
                else
                begin
                    stall_run = $urandom_range(1, 10);
                    next_stall = !out_stall;
                end
            end
        endcase
        out_stall <= next_stall;
    end

    // Result checker.
    always @(posedge clk)
    begin
        envelope_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            segments_seen++;
            if (channel_done)
                channels_seen++;
            if (pending_envelopes.size() == 0)
                note_mismatch($sformatf("result with none expected: min %0d max %0d done %0b",
                                        min_byte, max_byte, channel_done));
            else
            begin
                want = pending_envelopes.pop_front();
                if (min_byte !== want.lo_byte || max_byte !== want.hi_byte ||
                    channel_done !== want.done || channel_min !== want.lo_raw ||
                    channel_max !== want.hi_raw)
                    note_mismatch($sformatf(
                        "expected %0d/%0d done %0b ch %0d/%0d, got %0d/%0d done %0b ch %0d/%0d",
                        want.lo_byte, want.hi_byte, want.done, want.lo_raw, want.hi_raw,
                        min_byte, max_byte, channel_done, channel_min, channel_max));
            end
        end
    end

    initial
    begin
        #2_000_000;
        $display("end of test: mismatches");
        $finish;
    end

    initial
    begin
        int phase;
        int k;
        int max_len;
        logic [SEG_SIZE_W-1:0] size;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        drain();

        // Field extremes and the byte projection edges around -1.0 and +1.0.
        write_segment_size(17'd4);
        push_sample(24'sh7FFFFF, 1'b0);
        push_sample(-24'sd8388608, 1'b0);
        push_sample(24'sd0, 1'b0);
        push_sample(-24'sd65536, 1'b0);
        push_sample(24'sd65536, 1'b0);
        push_sample(24'sd65535, 1'b0);
        push_sample(-24'sd65537, 1'b1);
        drain();

        // A zero size closes a segment on every sample; includes a one-sample channel.
        gaps_on = 1'b1;
        stall_mode = STALL_RANDOM;
        write_segment_size('0);
        push_sample(-24'sd1, 1'b0);
        push_sample(24'sd1, 1'b1);
        push_sample(24'sh7FFFFF, 1'b1);
        drain();

        // Shrink the size while a segment is partly filled.
        write_segment_size(17'd8);
        for (k = 0; k < 6; k++)
            push_sample(random_sample(), 1'b0);
        drain();
        stall_mode = STALL_RUNS;
        write_segment_size(17'd3);
        push_sample(random_sample(), 1'b0);
        push_sample(random_sample(), 1'b0);
        push_sample(random_sample(), 1'b1);
        drain();

        // Oversized segment, cut short by the end of the channel.
        write_segment_size('1);
        push_sample(24'sd131072, 1'b0);
        push_sample(-24'sd131072, 1'b0);
        push_sample(24'sd32768, 1'b1);
        drain();

        for (phase = 0; phase < 12; phase++)
        begin
            case (phase % 6)
                0: size = SEG_SIZE_W'($urandom_range(1, 8));
                1: size = '0;
                2: size = 17'd65536;
                3: size = SEG_SIZE_W'($urandom_range(9, 40));
                4: size = '1;
                default: size = 17'd1;
            endcase
            gaps_on = (phase % 4 != 1);
            stall_mode = stall_mode_t'(phase % 3);
            write_segment_size(size);
            if (size == '0 || size > 20)
                max_len = 12;
            else
                max_len = 3 * size;
            queue_channels(70, max_len);
            drain();
        end

        mismatches += pending_envelopes.size();
        $display("covered %0d samples, %0d segment results, %0d channel ends",
                 samples_sent, segments_seen, channels_seen);
        $display("segment size written %0d times, from 0 up to 131071", size_writes);
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

>>> files.f
rtl/smmd_pkg.sv
rtl/smmd_proj.sv
rtl/smmd_core.sv
rtl/segment_min_max_decimator_unit.sv
sim/segment_min_max_decimator_unit_test.sv
